// ===== sv/asr_pkg.sv =====
// Shared types and constants of the axis sum reduction block.
// Used by asr_ctrl and axis_sum_reduction_core; depends on nothing.
package asr_pkg;

  localparam int AXIS_W  = 17;
  localparam int INNER_W = 11;
  localparam int OUTER_W = 17;
  localparam int CFG_W   = 17;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int IDX_W   = 26;
  localparam int REG_W   = 2;

  localparam logic [AXIS_W-1:0]  AXIS_MAX  = 17'd65536;
  localparam logic [OUTER_W-1:0] OUTER_MAX = 17'd65536;

  typedef enum logic [REG_W-1:0] {
    REG_AXIS_LENGTH = 2'd0,
    REG_INNER_COUNT = 2'd1,
    REG_OUTER_COUNT = 2'd2
  } reg_index_t;

  // Per-element control produced by the position sequencer.
  typedef struct packed {
    logic             load;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] index;
  } item_ctl_t;

endpackage

// ===== sv/asr_acc_ram.sv =====
// Accumulator memory: one write port and one registered read port.
// Read during a write to the same address returns the old contents.
module asr_acc_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/asr_ctrl.sv =====
// Configuration registers and tensor position counters.
// Depends on asr_pkg; feeds per-element control to the top level.
module asr_ctrl #(
  parameter int INNER_CAP = 1024,
  parameter int ADDR_W    = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [asr_pkg::REG_W-1:0] cfg_index,
  input  logic [asr_pkg::CFG_W-1:0] cfg_data,
  input  logic                     step,
  output asr_pkg::item_ctl_t       ctl,
  output logic [ADDR_W-1:0]        slot
);
  import asr_pkg::*;

  localparam logic [INNER_W-1:0] INNER_LIM = INNER_W'(INNER_CAP);

  logic [AXIS_W-1:0]  axis_len_r,  axis_len_nxt;
  logic [INNER_W-1:0] inner_cnt_r, inner_cnt_nxt;
  logic [OUTER_W-1:0] outer_cnt_r, outer_cnt_nxt;
  logic [AXIS_W-2:0]  axis_pos_r,  axis_pos_nxt;
  logic [INNER_W-1:0] inner_pos_r, inner_pos_nxt;
  logic [OUTER_W-2:0] outer_pos_r, outer_pos_nxt;
  logic [IDX_W-1:0]   result_idx_r, result_idx_nxt;

  logic [INNER_W-1:0] cfg_inner;
  logic               inner_end, axis_end, outer_end;

  assign cfg_inner = cfg_data[INNER_W-1:0];

  assign inner_end = (inner_pos_r + 11'd1) >= inner_cnt_r;
  assign axis_end  = ({1'b0, axis_pos_r} + 17'd1) >= axis_len_r;
  assign outer_end = ({1'b0, outer_pos_r} + 17'd1) >= outer_cnt_r;

  assign ctl.load  = (axis_pos_r == '0);
  assign ctl.emit  = axis_end;
  assign ctl.last  = outer_end && inner_end;
  assign ctl.index = result_idx_r;
  assign slot      = inner_pos_r[ADDR_W-1:0];

  always_comb begin
    axis_len_nxt   = axis_len_r;
    inner_cnt_nxt  = inner_cnt_r;
    outer_cnt_nxt  = outer_cnt_r;
    axis_pos_nxt   = axis_pos_r;
    inner_pos_nxt  = inner_pos_r;
    outer_pos_nxt  = outer_pos_r;
    result_idx_nxt = result_idx_r;
    if (cfg_we) begin
      // Zero acts as one and values above range saturate; a write to any of the three registers restarts.
      case (cfg_index)
        REG_AXIS_LENGTH: begin
          if (cfg_data == '0) begin
            axis_len_nxt = 17'd1;
          end else if (cfg_data > AXIS_MAX) begin
            axis_len_nxt = AXIS_MAX;
          end else begin
            axis_len_nxt = cfg_data;
          end
        end
        REG_INNER_COUNT: begin
          if (cfg_inner == '0) begin
            inner_cnt_nxt = 11'd1;
          end else if (cfg_inner > INNER_LIM) begin
            inner_cnt_nxt = INNER_LIM;
          end else begin
            inner_cnt_nxt = cfg_inner;
          end
        end
        REG_OUTER_COUNT: begin
          if (cfg_data == '0) begin
            outer_cnt_nxt = 17'd1;
          end else if (cfg_data > OUTER_MAX) begin
            outer_cnt_nxt = OUTER_MAX;
          end else begin
            outer_cnt_nxt = cfg_data;
          end
        end
        default: begin
        end
      endcase
      if (cfg_index == REG_AXIS_LENGTH || cfg_index == REG_INNER_COUNT ||
          cfg_index == REG_OUTER_COUNT) begin
        axis_pos_nxt   = '0;
        inner_pos_nxt  = '0;
        outer_pos_nxt  = '0;
        result_idx_nxt = '0;
      end
    end else if (step) begin
      if (axis_end) begin
        result_idx_nxt = result_idx_r + 26'd1;
      end
      if (inner_end) begin
        inner_pos_nxt = '0;
        if (axis_end) begin
          axis_pos_nxt = '0;
          if (outer_end) begin
            outer_pos_nxt  = '0;
            result_idx_nxt = '0;
          end else begin
            outer_pos_nxt = outer_pos_r + 16'd1;
          end
        end else begin
          axis_pos_nxt = axis_pos_r + 16'd1;
        end
      end else begin
        inner_pos_nxt = inner_pos_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_len_r   <= 17'd1;
      inner_cnt_r  <= 11'd1;
      outer_cnt_r  <= 17'd1;
      axis_pos_r   <= '0;
      inner_pos_r  <= '0;
      outer_pos_r  <= '0;
      result_idx_r <= '0;
    end else begin
      axis_len_r   <= axis_len_nxt;
      inner_cnt_r  <= inner_cnt_nxt;
      outer_cnt_r  <= outer_cnt_nxt;
      axis_pos_r   <= axis_pos_nxt;
      inner_pos_r  <= inner_pos_nxt;
      outer_pos_r  <= outer_pos_nxt;
      result_idx_r <= result_idx_nxt;
    end
  end

endmodule

// ===== sv/axis_sum_reduction_core.sv =====
// Top level of the axis sum reduction block: accumulate stage, output register.
// Depends on asr_pkg, asr_acc_ram and asr_ctrl.
//
// Sums a row-major tensor of outer_count x axis_length x inner_count signed
// Q16.16 elements along the middle axis and returns one Q32.16 sum per
// (outer, inner) pair with its flat index, the final one marked last. One
// element is taken every cycle. An element reads its accumulator from the
// memory in the cycle it is taken and the updated sum is written back as the
// element leaves the accumulate stage; a back-to-back update of the same
// accumulator is forwarded from the adder, so the rate holds for every
// inner_count. A sum of the last axis position goes from the accumulate stage
// to the output register. The only stall comes from the output side: while a
// result waits in the output register and the next element in the accumulate
// stage also produces a result, the input is not ready. Write configuration
// only between tensors; every register write restarts the tensor.
module axis_sum_reduction_core #(
  parameter int INNER_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asr_pkg::REG_W-1:0]           cfg_index,
  input  logic [asr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [asr_pkg::VAL_W-1:0]    in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [asr_pkg::SUM_W-1:0]    out_sum_value,
  output logic [asr_pkg::IDX_W-1:0]           out_index,
  output logic                                out_last_result
);
  import asr_pkg::*;

  localparam int INNER_CAP = (INNER_DEPTH > 2047) ? 2047 : INNER_DEPTH;
  localparam int ADDR_W    = (INNER_CAP > 1) ? $clog2(INNER_CAP) : 1;

  item_ctl_t          in_ctl;
  logic [ADDR_W-1:0]  in_slot;
  logic               in_fire;

  logic               s1_valid_r;
  item_ctl_t          s1_ctl_r;
  logic [ADDR_W-1:0]  s1_slot_r;
  logic [VAL_W-1:0]   s1_x_r;
  logic               s1_fwd_r;
  logic [SUM_W-1:0]   s1_fwd_data_r;
  logic               s1_go;
  logic [SUM_W-1:0]   rd_data;
  logic [SUM_W-1:0]   operand;
  logic [SUM_W-1:0]   x_ext;
  logic [SUM_W-1:0]   acc;

  logic               out_valid_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [IDX_W-1:0]   out_index_r;
  logic               out_last_r;

  assign cfg_ready = 1'b1;

  asr_ctrl #(
    .INNER_CAP (INNER_CAP),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_fire),
    .ctl       (in_ctl),
    .slot      (in_slot)
  );

  // The stage advances unless its result would land on a full output register that is not being read.
  assign s1_go    = s1_valid_r && (!s1_ctl_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  assign x_ext   = {{(SUM_W-VAL_W){s1_x_r[VAL_W-1]}}, s1_x_r};
  assign operand = s1_fwd_r ? s1_fwd_data_r : rd_data;
  assign acc     = s1_ctl_r.load ? x_ext : operand + x_ext;

  asr_acc_ram #(
    .DEPTH  (INNER_CAP),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_slot_r),
    .wdata (acc),
    .re    (in_fire),
    .raddr (in_slot),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // The memory read of a new element misses a write-back made at the same edge.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r      <= in_ctl;
      s1_slot_r     <= in_slot;
      s1_x_r        <= in_element_value;
      s1_fwd_r      <= s1_go && (s1_slot_r == in_slot);
      s1_fwd_data_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl_r.emit) begin
      out_sum_r   <= acc;
      out_index_r <= s1_ctl_r.index;
      out_last_r  <= s1_ctl_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sum_value   = out_sum_r;
  assign out_index       = out_index_r;
  assign out_last_result = out_last_r;

  a_fwd_on_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_go && (s1_slot_r == in_slot)) |=> s1_fwd_r)
    else $error("back-to-back update of one accumulator not forwarded");

  a_fire_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted element did not reach the accumulate stage");

  a_blocked_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.emit && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while the accumulate stage is blocked");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_index_r)))
    else $error("pending result lost from the output register");

endmodule

// ===== verif/tb_axis_sum_reduction_core.sv =====
// Self-checking testbench for axis_sum_reduction_core: directed table, random and edge tensors.
// Depends on asr_pkg and the axis_sum_reduction_core RTL with its submodules.
`timescale 1ns / 100ps

module tb_axis_sum_reduction_core;
  import asr_pkg::*;

  localparam int INNER_DEPTH    = 1024;
  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS   = 300;
  localparam int EDGE_ITEMS     = 16;
  localparam int DRAIN_CYCLES   = 4;

  // Index three decodes to no register, so a write there must be ignored.
  localparam logic [REG_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic [IDX_W-1:0]        out_index;
    logic                    last_result;
  } reduced_sum_t;

  typedef enum logic {ROW_ELEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [REG_W-1:0] reg_idx;
    logic [VAL_W-1:0] data;
    bit               typed;
    reduced_sum_t     want;
  } stim_row_t;

  localparam reduced_sum_t NO_SUM = '0;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [REG_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_sum_value;
  logic [IDX_W-1:0]        out_index;
  logic                    out_last_result;

  // Predictor state: accumulator bank, tensor positions and register copies.
  logic [SUM_W-1:0] acc_bank [INNER_DEPTH];
  int unsigned      axis_pos = 0;
  int unsigned      inner_pos = 0;
  int unsigned      outer_pos = 0;
  logic [IDX_W-1:0] sum_index = '0;
  int unsigned      axis_len = 1;
  int unsigned      inner_cnt = 1;
  int unsigned      outer_cnt = 1;

  reduced_sum_t expected_sums [$];
  int           fail_count = 0;
  bit           no_idle = 1'b0;

  stim_row_t directed_rows [29] = '{
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b1, '{48'h0000_7FFF_FFFF, 26'd0, 1'b1}},
    '{ROW_ELEM, '0, 32'h8000_0000, 1'b1, '{48'hFFFF_8000_0000, 26'd0, 1'b1}},
    '{ROW_ELEM, '0, 32'h0000_0000, 1'b1, '{48'h0000_0000_0000, 26'd0, 1'b1}},
    '{ROW_ELEM, '0, 32'hFFFF_FFFF, 1'b1, '{48'hFFFF_FFFF_FFFF, 26'd0, 1'b1}},
    '{ROW_CFG, REG_AXIS_LENGTH, 32'd3, 1'b0, NO_SUM},
    '{ROW_CFG, REG_INNER_COUNT, 32'd2, 1'b0, NO_SUM},
    '{ROW_CFG, REG_OUTER_COUNT, 32'd2, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h8000_0000, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h0001_0000, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'hFFFF_0000, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h1234_5678, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h8000_0000, 1'b0, NO_SUM},
    // Written a third of the way through the second slice, so the tensor restarts.
    '{ROW_CFG, REG_AXIS_LENGTH, 32'd0, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h0001_8000, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h8000_0001, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h0000_0001, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'hDEAD_BEEF, 1'b0, NO_SUM},
    // Only the low eleven bits count for the inner register, so this acts as zero.
    '{ROW_CFG, REG_INNER_COUNT, 32'h0000_0800, 1'b0, NO_SUM},
    '{ROW_CFG, REG_OUTER_COUNT, 32'h0001_FFFF, 1'b0, NO_SUM},
    '{ROW_CFG, REG_AXIS_LENGTH, 32'd2, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{ROW_CFG, REG_SPARE, 32'h0001_FFFF, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h7FFF_FFFF, 1'b1, '{48'h0000_FFFF_FFFE, 26'd0, 1'b0}},
    '{ROW_ELEM, '0, 32'h8000_0000, 1'b0, NO_SUM},
    '{ROW_ELEM, '0, 32'h8000_0000, 1'b1, '{48'hFFFF_0000_0000, 26'd1, 1'b0}}
  };

  axis_sum_reduction_core #(
    .INNER_DEPTH(INNER_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_value(in_element_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_value   (out_sum_value),
    .out_index       (out_index),
    .out_last_result (out_last_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void apply_reg_write(input logic [REG_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    case (idx)
      REG_AXIS_LENGTH: axis_len  = clamp_count(data, AXIS_MAX);
      REG_INNER_COUNT: inner_cnt = clamp_count(data[INNER_W-1:0], INNER_DEPTH);
      REG_OUTER_COUNT: outer_cnt = clamp_count(data, OUTER_MAX);
      default: return;
    endcase
    axis_pos  = 0;
    inner_pos = 0;
    outer_pos = 0;
    sum_index = '0;
  endfunction

  // Advances the tensor by one element and reports the finished sum, if any.
  function automatic bit reduce_element(input logic [VAL_W-1:0] element,
                                        output reduced_sum_t res);
    logic [SUM_W-1:0] widened;
    logic [SUM_W-1:0] acc;
    bit               emit;
    widened = {{(SUM_W-VAL_W){element[VAL_W-1]}}, element};
    acc = (axis_pos == 0) ? widened : acc_bank[inner_pos] + widened;
    acc_bank[inner_pos] = acc;
    emit = (axis_pos + 1 >= axis_len);
    res = '0;
    if (emit) begin
      res.sum_value   = acc;
      res.out_index   = sum_index;
      res.last_result = (outer_pos + 1 >= outer_cnt) && (inner_pos + 1 >= inner_cnt);
      sum_index++;
    end
    inner_pos++;
    if (inner_pos >= inner_cnt) begin
      inner_pos = 0;
      axis_pos++;
      if (axis_pos >= axis_len) begin
        axis_pos = 0;
        outer_pos++;
        if (outer_pos >= outer_cnt) begin
          outer_pos = 0;
          sum_index = '0;
        end
      end
    end
    return emit;
  endfunction

  function automatic logic [VAL_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count(input int unsigned hi);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic send_element(input logic [VAL_W-1:0] value, input bit typed,
                              input reduced_sum_t want);
    int unsigned  gap;
    reduced_sum_t res;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (cfg_valid) cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= value;
    do @(posedge clk); while (!in_ready);
    if (reduce_element(value, res)) expected_sums = {expected_sums, typed ? want : res};
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
  endtask

  // Holds the input off until every pending sum has been taken and the
  // accumulate stage has had time to retire elements that emit nothing.
  task automatic settle();
    in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    reduced_sum_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("out_index: no sum pending, got %0d", out_index);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_sum_value !== want.sum_value) begin
          $error("out_sum_value: expected %h, got %h", want.sum_value, out_sum_value);
          fail_count++;
        end
        if (out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, out_index);
          fail_count++;
        end
        if (out_last_result !== want.last_result) begin
          $error("out_last_result: expected %b, got %b", want.last_result, out_last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned       rand_items;
    int unsigned       phase;
    int unsigned       count;
    int unsigned       cap;
    longint unsigned   tensor;
    rand_items = 0;
    phase = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (r == 0 || directed_rows[r-1].kind == ROW_ELEM) settle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].data[CFG_W-1:0]);
      end else begin
        send_element(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    while (rand_items < RANDOM_ITEMS) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      write_reg(REG_AXIS_LENGTH, pick_count(4));
      write_reg(REG_INNER_COUNT, pick_count(4));
      write_reg(REG_OUTER_COUNT, pick_count(3));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
      tensor = longint'(axis_len) * inner_cnt * outer_cnt;
      cap = (tensor < 40) ? int'(tensor) : 40;
      // A quarter of the phases send a random number of elements, so the next
      // register write may land mid-tensor.
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, cap);
      else count = cap * $urandom_range(1, 2);
      for (int k = 0; k < count; k++) begin
        if ((phase == 0 && k == count / 2) || $urandom_range(0, 63) == 0) settle();
        send_element(pick_element(), 1'b0, NO_SUM);
      end
      rand_items += count;
      phase++;
    end

    // Longest axis at both signs, each cut short by the next register write.
    settle();
    no_idle = 1'b1;
    write_reg(REG_AXIS_LENGTH, 17'h1FFFF);
    write_reg(REG_INNER_COUNT, 17'd1);
    write_reg(REG_OUTER_COUNT, 17'd1);
    repeat (EDGE_ITEMS) send_element(32'h7FFF_FFFF, 1'b0, NO_SUM);
    settle();
    write_reg(REG_AXIS_LENGTH, AXIS_MAX);
    repeat (EDGE_ITEMS) send_element(32'h8000_0000, 1'b0, NO_SUM);

    // Inner register above the bank depth saturates; each element is a sum.
    settle();
    write_reg(REG_AXIS_LENGTH, 17'd1);
    write_reg(REG_INNER_COUNT, 17'h1FFFF);
    write_reg(REG_OUTER_COUNT, 17'd1);
    repeat (EDGE_ITEMS) send_element(pick_element(), 1'b0, NO_SUM);

    settle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("tb_axis_sum_reduction_core passed");
    end else begin
      $display("tb_axis_sum_reduction_core failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_axis_sum_reduction_core failed");
    $finish;
  end

endmodule
